FILE: src/quaternion_cube_wireframe_edges_macros.svh
// Assertion macros for the cube wireframe edge block.
// Used by the top level only; compiled out when SYNTH is defined.
`ifndef QUATERNION_CUBE_WIREFRAME_EDGES_MACROS_SVH
`define QUATERNION_CUBE_WIREFRAME_EDGES_MACROS_SVH
`ifndef SYNTH
`define QCWE_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("qcwe check failed");
`define QCWE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qcwe check failed");
`else
`define QCWE_ASSERT(label, expr)
`define QCWE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: src/qcwe_pkg.sv
// Types, register codes and edge table for the cube wireframe edge block.
// No dependencies.
package qcwe_pkg;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } qcwe_in_t;

  typedef struct packed {
    logic [9:0] start_x;
    logic [9:0] start_y;
    logic [9:0] end_x;
    logic [9:0] end_y;
    logic [3:0] edge_index;
    logic       empty_res;
    logic       last;
  } qcwe_out_t;

  typedef enum logic [2:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_CUBE_SCALE    = 3'd2,
    REG_CANVAS_WIDTH  = 3'd3,
    REG_CANVAS_HEIGHT = 3'd4
  } qcwe_reg_t;

  localparam int CFG_DATA_W = 14;
  localparam int NUM_EDGES  = 12;

  localparam logic [9:0]  CENTER_X_RST      = 10'd64;
  localparam logic [9:0]  CENTER_Y_RST      = 10'd64;
  localparam logic [13:0] CUBE_SCALE_RST    = 14'd320;
  localparam logic [9:0]  CANVAS_WIDTH_RST  = 10'd127;
  localparam logic [9:0]  CANVAS_HEIGHT_RST = 10'd127;

  // one in Q.28, visibility threshold (2 LSB of Q1.14 in Q.28), rounding half in Q.32
  localparam logic signed [34:0] ONE_Q28   = 35'sd268435456;
  localparam logic signed [34:0] VIS_LIMIT = 35'sd32768;
  localparam logic [51:0]        HALF_Q32  = 52'd2147483648;

  // faces: 0 -X, 1 +X, 2 -Y, 3 +Y, 4 -Z, 5 +Z; vertex bit0 X, bit1 Y, bit2 Z
  localparam logic [2:0] EDGE_VA [NUM_EDGES] =
    '{3'd0, 3'd2, 3'd4, 3'd6, 3'd0, 3'd1, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3};
  localparam logic [2:0] EDGE_VB [NUM_EDGES] =
    '{3'd1, 3'd3, 3'd5, 3'd7, 3'd2, 3'd3, 3'd6, 3'd7, 3'd4, 3'd5, 3'd6, 3'd7};
  localparam logic [2:0] EDGE_FA [NUM_EDGES] =
    '{3'd2, 3'd3, 3'd2, 3'd3, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1};
  localparam logic [2:0] EDGE_FB [NUM_EDGES] =
    '{3'd4, 3'd4, 3'd5, 3'd5, 3'd4, 3'd4, 3'd5, 3'd5, 3'd2, 3'd2, 3'd3, 3'd3};

endpackage

FILE: src/quaternion_cube_wireframe_edges.sv
// Top level of the cube wireframe edge block: rotation, projection, culling, output.
// Depends on qcwe_pkg and quaternion_cube_wireframe_edges_macros.svh.
//
// One quaternion enters per cycle while in_ready is high, into a six stage pipeline
// (products, matrix, corner sums, scale multiply, round and clamp, edge culling),
// then passes the hold register and the output register. The output side sends
// one segment per cycle while out_ready allows, so a quaternion gives max(1, visible
// segments) transfers, up to nine; that edge serializer sets the sustained rate.
// A quaternion waits in a hold register while its segments go out. When the
// receiver stalls, the hold register and then the stages fill up and in_ready drops.
// Configuration writes are always accepted and take effect at once; write them
// only while the block is idle.
`include "quaternion_cube_wireframe_edges_macros.svh"

module quaternion_cube_wireframe_edges (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qcwe_pkg::qcwe_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qcwe_pkg::qcwe_out_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [qcwe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qcwe_pkg::*;

  logic [9:0]  center_x, center_y, canvas_width, canvas_height;
  logic [13:0] cube_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= CENTER_X_RST;
      center_y      <= CENTER_Y_RST;
      cube_scale    <= CUBE_SCALE_RST;
      canvas_width  <= CANVAS_WIDTH_RST;
      canvas_height <= CANVAS_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X:      center_x      <= cfg_data[9:0];
        REG_CENTER_Y:      center_y      <= cfg_data[9:0];
        REG_CUBE_SCALE:    cube_scale    <= cfg_data;
        REG_CANVAS_WIDTH:  canvas_width  <= cfg_data[9:0];
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and advance chain
  logic [6:1] stg_valid;
  logic [7:1] adv;
  logic       hold_load;

  always_comb begin
    adv[7] = hold_load;
    for (int k = 6; k >= 1; k--) adv[k] = !stg_valid[k] || adv[k+1];
  end
  assign in_ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else begin
      if (adv[1]) stg_valid[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (adv[k]) stg_valid[k] <= stg_valid[k-1];
      end
    end
  end

  // stage 1: products
  logic signed [31:0] p_xx, p_yy, p_zz, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      p_xx <= in_data.quat_x * in_data.quat_x;
      p_yy <= in_data.quat_y * in_data.quat_y;
      p_zz <= in_data.quat_z * in_data.quat_z;
      p_xy <= in_data.quat_x * in_data.quat_y;
      p_wz <= in_data.quat_w * in_data.quat_z;
      p_xz <= in_data.quat_x * in_data.quat_z;
      p_wy <= in_data.quat_w * in_data.quat_y;
      p_yz <= in_data.quat_y * in_data.quat_z;
      p_wx <= in_data.quat_w * in_data.quat_x;
    end
  end

  // stage 2: rotation matrix, Q.28
  logic signed [34:0] m [3][3];
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      m[0][0] <= ONE_Q28 - ((35'(p_yy) + 35'(p_zz)) <<< 1);
      m[0][1] <= (35'(p_xy) - 35'(p_wz)) <<< 1;
      m[0][2] <= (35'(p_xz) + 35'(p_wy)) <<< 1;
      m[1][0] <= (35'(p_xy) + 35'(p_wz)) <<< 1;
      m[1][1] <= ONE_Q28 - ((35'(p_xx) + 35'(p_zz)) <<< 1);
      m[1][2] <= (35'(p_yz) - 35'(p_wx)) <<< 1;
      m[2][0] <= (35'(p_xz) - 35'(p_wy)) <<< 1;
      m[2][1] <= (35'(p_yz) + 35'(p_wx)) <<< 1;
      m[2][2] <= ONE_Q28 - ((35'(p_xx) + 35'(p_yy)) <<< 1);
    end
  end

  // stage 3: corner projections and face visibility
  logic signed [35:0] cpx [8];
  logic signed [35:0] cpy [8];
  logic [5:0]         vis3, vis4, vis5;
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 8; i++) begin
        cpx[i] <= (i[0] ? 36'(m[0][0]) : -36'(m[0][0]))
                + (i[1] ? 36'(m[0][1]) : -36'(m[0][1]))
                + (i[2] ? 36'(m[0][2]) : -36'(m[0][2]));
        cpy[i] <= (i[0] ? 36'(m[1][0]) : -36'(m[1][0]))
                + (i[1] ? 36'(m[1][1]) : -36'(m[1][1]))
                + (i[2] ? 36'(m[1][2]) : -36'(m[1][2]));
      end
      for (int k = 0; k < 3; k++) begin
        vis3[2*k]   <= m[2][k] < -VIS_LIMIT;
        vis3[2*k+1] <= m[2][k] > VIS_LIMIT;
      end
    end
  end

  // stage 4: center*2^32 - scale*p, Q.32
  logic signed [51:0] vx [8];
  logic signed [51:0] vy [8];
  logic signed [14:0] scale_s;
  logic signed [51:0] cx_q32, cy_q32;
  assign scale_s = $signed({1'b0, cube_scale});
  assign cx_q32  = $signed({10'd0, center_x, 32'd0});
  assign cy_q32  = $signed({10'd0, center_y, 32'd0});
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int i = 0; i < 8; i++) begin
        vx[i] <= cx_q32 - 52'(scale_s * cpx[i]);
        vy[i] <= cy_q32 - 52'(scale_s * cpy[i]);
      end
      vis4 <= vis3;
    end
  end

  // stage 5: round half up, clamp negatives to zero and large values to the limit
  function automatic logic [9:0] round_clamp(logic signed [51:0] v, logic [9:0] limit);
    logic [51:0] t;
    logic [19:0] r;
    t = $unsigned(v) + HALF_Q32;
    r = t[51:32];
    if (v < 0) return 10'd0;
    if (r > 20'(limit)) return limit;
    return r[9:0];
  endfunction

  logic [9:0] sx5 [8];
  logic [9:0] sy5 [8];
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int i = 0; i < 8; i++) begin
        sx5[i] <= round_clamp(vx[i], canvas_width);
        sy5[i] <= round_clamp(vy[i], canvas_height);
      end
      vis5 <= vis4;
    end
  end

  // stage 6: edge culling
  logic [9:0]           sx6 [8];
  logic [9:0]           sy6 [8];
  logic [NUM_EDGES-1:0] mask6;
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      sx6 <= sx5;
      sy6 <= sy5;
      for (int e = 0; e < NUM_EDGES; e++) begin
        mask6[e] <= (vis5[EDGE_FA[e]] || vis5[EDGE_FB[e]])
                 && !(sx5[EDGE_VA[e]] == sx5[EDGE_VB[e]]
                      && sy5[EDGE_VA[e]] == sy5[EDGE_VB[e]]);
      end
    end
  end

  // edge serializer
  logic                 hold_valid;
  logic [9:0]           hold_sx [8];
  logic [9:0]           hold_sy [8];
  logic [NUM_EDGES-1:0] hold_mask, rem_mask;
  logic [3:0]           pick;
  logic                 emit, done;

  always_comb begin
    pick = '0;
    for (int e = NUM_EDGES - 1; e >= 0; e--) begin
      if (hold_mask[e]) pick = 4'(e);
    end
  end
  assign rem_mask  = hold_mask & ~(NUM_EDGES'(1) << pick);
  assign emit      = hold_valid && (!out_valid || out_ready);
  assign done      = (hold_mask == '0) || (rem_mask == '0);
  assign hold_load = !hold_valid || (emit && done);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (hold_load) begin
        hold_valid <= stg_valid[6];
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_load) begin
      hold_sx   <= sx6;
      hold_sy   <= sy6;
      hold_mask <= mask6;
    end else if (emit) begin
      hold_mask <= rem_mask;
    end
    if (emit) begin
      if (hold_mask == '0) begin
        out_data <= '{start_x: 10'd0, start_y: 10'd0, end_x: 10'd0, end_y: 10'd0,
                      edge_index: 4'd0, empty_res: 1'b1, last: 1'b1};
      end else begin
        out_data.start_x    <= hold_sx[EDGE_VA[pick]];
        out_data.start_y    <= hold_sy[EDGE_VA[pick]];
        out_data.end_x      <= hold_sx[EDGE_VB[pick]];
        out_data.end_y      <= hold_sy[EDGE_VB[pick]];
        out_data.edge_index <= pick;
        out_data.empty_res  <= 1'b0;
        out_data.last       <= rem_mask == '0;
      end
    end
  end

  `QCWE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `QCWE_ASSERT(a_empty_last, !out_valid || !out_data.empty_res || out_data.last)
  `QCWE_ASSERT(a_edge_range, !out_valid || out_data.edge_index < 4'(NUM_EDGES))
  `QCWE_ASSERT(a_seg_distinct, !out_valid || out_data.empty_res || out_data.start_x != out_data.end_x || out_data.start_y != out_data.end_y)

endmodule

FILE: verif/qcwe_checker.sv
// Checker for the cube wireframe edge block: predicts segments per quaternion and
// compares every output transfer. Depends on qcwe_pkg.
`timescale 1ns / 1ps

module qcwe_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  qcwe_pkg::qcwe_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  qcwe_pkg::qcwe_out_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [qcwe_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  seg_count,
  output int                  empty_count
);
  import qcwe_pkg::*;

  logic [9:0]  cx, cy, cw, chgt;
  logic [13:0] scl;
  qcwe_out_t   seg_queue[$];

  assign pending = seg_queue.size();

  task automatic report(input string what, input qcwe_out_t got, input qcwe_out_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic logic [9:0] to_screen(logic [9:0] c, logic [13:0] s,
                                           longint p, logic [9:0] lim);
    longint v, r;
    v = longint'(c) * (64'sd1 <<< 32) - longint'(s) * p;
    if (v < 0) return 10'd0;
    r = (v + 64'sd2147483648) >>> 32;
    return (r > longint'(lim)) ? lim : r[9:0];
  endfunction

  task automatic predict_segments(input qcwe_in_t q);
    longint w, x, y, z, px, py, nz;
    longint m[3][3];
    logic [9:0] sx[8], sy[8];
    logic vis[6];
    int n;
    qcwe_out_t o;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    m[0][0] = (64'sd1 <<< 28) - 2 * (y * y + z * z);
    m[0][1] = 2 * (x * y - w * z);
    m[0][2] = 2 * (x * z + w * y);
    m[1][0] = 2 * (x * y + w * z);
    m[1][1] = (64'sd1 <<< 28) - 2 * (x * x + z * z);
    m[1][2] = 2 * (y * z - w * x);
    m[2][0] = 2 * (x * z - w * y);
    m[2][1] = 2 * (y * z + w * x);
    m[2][2] = (64'sd1 <<< 28) - 2 * (x * x + y * y);
    for (int i = 0; i < 8; i++) begin
      px = (i[0] ? m[0][0] : -m[0][0]) + (i[1] ? m[0][1] : -m[0][1])
         + (i[2] ? m[0][2] : -m[0][2]);
      py = (i[0] ? m[1][0] : -m[1][0]) + (i[1] ? m[1][1] : -m[1][1])
         + (i[2] ? m[1][2] : -m[1][2]);
      sx[i] = to_screen(cx, scl, px, cw);
      sy[i] = to_screen(cy, scl, py, chgt);
    end
    for (int f = 0; f < 6; f++) begin
      nz = f[0] ? m[2][f >> 1] : -m[2][f >> 1];
      vis[f] = nz > 64'sd32768;
    end
    n = 0;
    for (int e = 0; e < NUM_EDGES; e++) begin
      if (!(vis[EDGE_FA[e]] || vis[EDGE_FB[e]])) continue;
      if (sx[EDGE_VA[e]] == sx[EDGE_VB[e]] && sy[EDGE_VA[e]] == sy[EDGE_VB[e]]) continue;
      o = '0;
      o.start_x = sx[EDGE_VA[e]]; o.start_y = sy[EDGE_VA[e]];
      o.end_x = sx[EDGE_VB[e]]; o.end_y = sy[EDGE_VB[e]];
      o.edge_index = e[3:0];
      seg_queue.push_back(o);
      n++;
    end
    if (n == 0) begin
      o = '0; o.empty_res = 1'b1; o.last = 1'b1;
      seg_queue.push_back(o);
    end else begin
      seg_queue[$].last = 1'b1;
    end
  endtask

  initial begin
    fail_count = 0; seg_count = 0; empty_count = 0;
  end

  always @(posedge clk) begin
    qcwe_out_t want;
    if (rst) begin
      cx <= CENTER_X_RST; cy <= CENTER_Y_RST; scl <= CUBE_SCALE_RST;
      cw <= CANVAS_WIDTH_RST; chgt <= CANVAS_HEIGHT_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_X:      cx <= cfg_data[9:0];
          REG_CENTER_Y:      cy <= cfg_data[9:0];
          REG_CUBE_SCALE:    scl <= cfg_data;
          REG_CANVAS_WIDTH:  cw <= cfg_data[9:0];
          REG_CANVAS_HEIGHT: chgt <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_segments(in_data);
      if (out_valid && out_ready) begin
        if (seg_queue.size() == 0) begin
          want = '0;
          report("unexpected transfer", out_data, want);
        end else begin
          want = seg_queue.pop_front();
          if (out_data.empty_res) empty_count++; else seg_count++;
          if (out_data.start_x !== want.start_x) report("start_x", out_data, want);
          if (out_data.start_y !== want.start_y) report("start_y", out_data, want);
          if (out_data.end_x !== want.end_x) report("end_x", out_data, want);
          if (out_data.end_y !== want.end_y) report("end_y", out_data, want);
          if (out_data.edge_index !== want.edge_index) report("edge_index", out_data, want);
          if (out_data.empty_res !== want.empty_res) report("empty_res", out_data, want);
          if (out_data.last !== want.last) report("last", out_data, want);
        end
      end
    end
  end
endmodule

FILE: verif/quaternion_cube_wireframe_edges_tb.sv
// Testbench top for the cube wireframe edge block: stimulus, config phases, verdict.
// Depends on qcwe_pkg, qcwe_checker and the block itself.
`timescale 1ns / 1ps

module quaternion_cube_wireframe_edges_tb;
  import qcwe_pkg::*;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  qcwe_in_t  in_data;
  qcwe_out_t out_data;
  logic [2:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending, seg_count, empty_count;
  int quat_count;
  logic hold_off;

  quaternion_cube_wireframe_edges DUT (.*);

  qcwe_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("[quaternion_cube_wireframe_edges] ERROR");
    $finish;
  end

  // receiver stall pattern, plus a long hold-off on request
  initial begin
    int mode;
    out_ready = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 1'b0;
      else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // leaves valid high; the caller sends again or drops valid in the same step
  task automatic send_quat(input logic signed [15:0] w, x, y, z);
    in_valid <= 1'b1;
    in_data <= '{quat_w: w, quat_x: x, quat_y: y, quat_z: z};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    quat_count++;
  endtask

  // bursts of random length separated by random gaps
  task automatic send_random(input int n, input bit well_formed);
    int burst;
    int gap;
    logic signed [15:0] v[4];
    real a, b, c, d, nrm;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 10);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      if (well_formed) begin
        a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
        c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
        nrm = $sqrt(a * a + b * b + c * c + d * d) + 1e-3;
        v[0] = 16'($rtoi(16384.0 * a / nrm)); v[1] = 16'($rtoi(16384.0 * b / nrm));
        v[2] = 16'($rtoi(16384.0 * c / nrm)); v[3] = 16'($rtoi(16384.0 * d / nrm));
      end else begin
        foreach (v[k]) v[k] = 16'($urandom());
      end
      send_quat(v[0], v[1], v[2], v[3]);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input qcwe_reg_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_view(input int x, y, s, wd, ht);
    write_reg(REG_CENTER_X, x);
    write_reg(REG_CENTER_Y, y);
    write_reg(REG_CUBE_SCALE, s);
    write_reg(REG_CANVAS_WIDTH, wd);
    write_reg(REG_CANVAS_HEIGHT, ht);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst = 1; in_valid = 0; in_data = '0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    hold_off = 0; quat_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity, axis turns, extremes, null and oversize quaternions
    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(11585, 11585, 0, 0);
    send_quat(11585, 0, 11585, 0);
    send_quat(14189, 4096, 4096, 4096);
    send_quat(0, 0, 0, 0);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, 32767, -1, 1);
    send_quat(11585, -11585, 0, 0);
    send_quat(16384, 0, 0, 1);
    drain();

    // extremes of the registers: zero scale / minimal canvas, then full range
    set_view(0, 0, 0, 1, 1);
    send_quat(16384, 0, 0, 0);
    send_quat(14189, 4096, 4096, 4096);
    drain();
    set_view(1023, 1023, 16383, 1023, 1023);
    send_quat(16384, 0, 0, 0);
    send_quat(13000, 5000, -6000, 3000);
    send_quat(-32768, -32768, 32767, 32767);
    drain();
    set_view(512, 300, 1600, 1023, 600);
    send_random(30, 1);
    send_random(8, 0);

    // long receiver hold-off while the sender keeps offering
    hold_off <= 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      send_random(20, 1);
    join
    drain();

    set_view($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 16383),
             $urandom_range(1, 1023), $urandom_range(1, 1023));
    send_random(30, 1);
    send_random(8, 0);
    drain();
    set_view(64, 64, 320, 127, 127);
    send_random(10, 1);
    drain();

    $display("sent %0d quaternions under six register settings: %0d segments, %0d empty",
             quat_count, seg_count, empty_count);
    if (fail_count == 0) begin
      $display("[quaternion_cube_wireframe_edges] OK");
    end else begin
      $display("[quaternion_cube_wireframe_edges] ERROR");
    end
    $finish;
  end
endmodule
